[rtl/core/asgr_pkg.sv]
// ----------------------------------------------------------------------------
// asgr_pkg: shared types and constants of the SGR style parser
// Buffer sizing, controller/datapath command and status, result payload.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package asgr_pkg;

  // Depth of the held escape sequence buffer (range 4..64)
  localparam int unsigned SEQ_BUFFER_DEPTH = 16;
  localparam int unsigned IDX_W = $clog2(SEQ_BUFFER_DEPTH);
  localparam int unsigned CNT_W = $clog2(SEQ_BUFFER_DEPTH + 1);

  // What the current byte does to the parse state once any release is done
  typedef enum logic [1:0] {
    ACT_IDLE  = 2'd0,  // handle byte from idle: print it, or hold a lone ESC
    ACT_OPEN  = 2'd1,  // start a fresh ESC '[' sequence
    ACT_APPLY = 2'd2,  // closing 'm': commit trial style
    ACT_STORE = 2'd3   // parameter byte into the buffer
  } act_e;

  // Source of an emitted result
  typedef enum logic [1:0] {
    SRC_HELD = 2'd0,
    SRC_BYTE = 2'd1,
    SRC_BARE = 2'd2
  } src_e;

  typedef struct packed {
    logic latch;      // input transfer, capture byte and line end
    logic use_in;     // classify the input port byte, not the captured one
    logic act_en;     // perform the action on parse state
    logic idx_clr;
    logic idx_inc;
    logic emit;       // load the result register
    src_e src;
    logic ovf;
    logic line_done;
    logic run_last;
    logic eol_clr;    // end of line: drop held bytes, reset style
  } dp_cmd_t;

  typedef struct packed {
    act_e kind;
    logic rep_zero;   // nothing to release before the action
    logic rep_ovf;    // release is an overflow release
    logic emits_b;    // action prints the byte
    logic new_idle;   // parse mode is idle after the action
    logic eol;
    logic last_rep;   // release index at last byte of the release
    logic last_held;  // release index at last held byte
  } dp_status_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       has_char;
    logic       bold;
    logic [4:0] fg_color;
    logic       segment_start;
    logic       overflow;
    logic       line_done;
    logic       run_last;
  } res_t;

endpackage

`default_nettype wire

[rtl/core/asgr_if.sv]
// ----------------------------------------------------------------------------
// asgr_if: valid/ready channels of the SGR style parser
// Input byte channel and styled result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface asgr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       end_of_line;

  modport source (output valid, output byte_in, output end_of_line, input ready);
  modport sink   (input valid, input byte_in, input end_of_line, output ready);
endinterface

interface asgr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;
  logic       has_char;
  logic       bold;
  logic [4:0] fg_color;
  logic       segment_start;
  logic       overflow;
  logic       line_done;
  logic       run_last;

  modport source (output valid, output char_out, output has_char, output bold,
                  output fg_color, output segment_start, output overflow,
                  output line_done, output run_last, input ready);
  modport sink   (input valid, input char_out, input has_char, input bold,
                  input fg_color, input segment_start, input overflow,
                  input line_done, input run_last, output ready);
endinterface

`default_nettype wire

[rtl/core/asgr_datapath.sv]
// ----------------------------------------------------------------------------
// asgr_datapath: parse state, held byte buffer, style and result register
// Classifies each byte and executes controller commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module asgr_datapath (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [7:0]          in_byte_i,
  input  wire logic                in_eol_i,
  input  asgr_pkg::dp_cmd_t        cmd_i,
  output asgr_pkg::dp_status_t     status_o,
  output asgr_pkg::res_t           res_o
);
  import asgr_pkg::*;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'b001,
    MODE_ESC  = 3'b010,
    MODE_SEQ  = 3'b100
  } mode_e;

  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_M     = 8'h6D;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] FINAL_LO = 8'h40;
  localparam logic [7:0] FINAL_HI = 8'h7E;

  localparam logic [6:0] TOKEN_MAX  = 7'd127;
  localparam logic [6:0] SGR_RESET  = 7'd0;
  localparam logic [6:0] SGR_BOLD   = 7'd1;
  localparam logic [6:0] SGR_NORMAL = 7'd22;
  localparam logic [6:0] SGR_FG_LO  = 7'd30;
  localparam logic [6:0] SGR_FG_HI  = 7'd37;
  localparam logic [6:0] SGR_FG_DEF = 7'd39;
  localparam logic [6:0] SGR_BR_LO  = 7'd90;
  localparam logic [6:0] SGR_BR_HI  = 7'd97;
  localparam logic [6:0] FG_OFS     = 7'd29;  // 30 -> color 1
  localparam logic [6:0] BR_OFS     = 7'd81;  // 90 -> color 9

  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(SEQ_BUFFER_DEPTH);

  logic [7:0]       held_q [SEQ_BUFFER_DEPTH];
  mode_e            mode_q, mode_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             last_esc_q, last_esc_d;
  logic             sty_bold_q, sty_bold_d;
  logic [4:0]       sty_fg_q, sty_fg_d;
  logic             tr_bold_q, tr_bold_d;
  logic [4:0]       tr_fg_q, tr_fg_d;
  logic [6:0]       tok_q, tok_d;
  logic             tok_inv_q, tok_inv_d;
  logic             new_seg_q, new_seg_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [7:0]       byte_q;
  logic             eol_q;
  res_t             res_q;

  logic [7:0]       cb;
  logic             ceol;
  logic             is_final, trail;
  act_e             act_kind;
  logic             rep_ovf;
  logic [CNT_W-1:0] rep_len;
  logic             ap_bold;
  logic [4:0]       ap_fg;
  logic [10:0]      tok_acc;
  logic [6:0]       tok_sat;
  logic             now_bold;
  logic [4:0]       now_fg;

  assign cb   = cmd_i.use_in ? in_byte_i : byte_q;
  assign ceol = cmd_i.use_in ? in_eol_i : eol_q;

  // Byte classification against the current parse mode
  assign is_final = (cb >= FINAL_LO) && (cb <= FINAL_HI);
  assign trail    = (cb == CH_LBRK) && (cnt_q > CNT_W'(2)) && last_esc_q;

  always_comb begin
    act_kind = ACT_IDLE;
    rep_ovf  = 1'b0;
    rep_len  = '0;
    case (mode_q)
      MODE_ESC: begin
        if (cb == CH_LBRK) begin
          act_kind = ACT_OPEN;
        end else begin
          rep_len = cnt_q;
        end
      end
      MODE_SEQ: begin
        if (cb == CH_M) begin
          act_kind = ACT_APPLY;
        end else if (is_final) begin
          if (trail) begin
            // ESC '[' at the tail: print what came before, reopen
            act_kind = ACT_OPEN;
            rep_len  = cnt_q - CNT_W'(1);
          end else begin
            rep_len = cnt_q;
          end
        end else if (cnt_q >= DEPTH_C) begin
          rep_len = cnt_q;
          rep_ovf = 1'b1;
        end else begin
          act_kind = ACT_STORE;
        end
      end
      default: begin
        act_kind = ACT_IDLE;
      end
    endcase
  end

  assign status_o.kind      = act_kind;
  assign status_o.rep_ovf   = rep_ovf;
  assign status_o.rep_zero  = (rep_len == '0);
  assign status_o.emits_b   = (act_kind == ACT_IDLE) && (cb != CH_ESC);
  assign status_o.new_idle  = (act_kind == ACT_APPLY) || status_o.emits_b;
  assign status_o.eol       = ceol;
  assign status_o.last_rep  = (CNT_W'(idx_q) == rep_len - CNT_W'(1));
  assign status_o.last_held = (CNT_W'(idx_q) == cnt_q - CNT_W'(1));

  // Pending token applied to the trial style
  always_comb begin
    ap_bold = tr_bold_q;
    ap_fg   = tr_fg_q;
    if (!tok_inv_q) begin
      if (tok_q == SGR_RESET) begin
        ap_bold = 1'b0;
        ap_fg   = '0;
      end else if (tok_q == SGR_BOLD) begin
        ap_bold = 1'b1;
      end else if (tok_q == SGR_NORMAL) begin
        ap_bold = 1'b0;
      end else if (tok_q >= SGR_FG_LO && tok_q <= SGR_FG_HI) begin
        ap_fg = 5'(tok_q - FG_OFS);
      end else if (tok_q == SGR_FG_DEF) begin
        ap_fg = '0;
      end else if (tok_q >= SGR_BR_LO && tok_q <= SGR_BR_HI) begin
        ap_fg = 5'(tok_q - BR_OFS);
      end
    end
  end

  // Decimal accumulate, saturating
  assign tok_acc = 11'({tok_q, 3'b000}) + 11'({tok_q, 1'b0}) + 11'(cb - CH_0);
  assign tok_sat = (tok_acc > 11'(TOKEN_MAX)) ? TOKEN_MAX : tok_acc[6:0];

  // A bare line end right after 'm' carries the style just committed
  assign now_bold = (cmd_i.act_en && act_kind == ACT_APPLY) ? ap_bold : sty_bold_q;
  assign now_fg   = (cmd_i.act_en && act_kind == ACT_APPLY) ? ap_fg : sty_fg_q;

  always_comb begin
    mode_d     = mode_q;
    cnt_d      = cnt_q;
    last_esc_d = last_esc_q;
    sty_bold_d = sty_bold_q;
    sty_fg_d   = sty_fg_q;
    tr_bold_d  = tr_bold_q;
    tr_fg_d    = tr_fg_q;
    tok_d      = tok_q;
    tok_inv_d  = tok_inv_q;
    new_seg_d  = new_seg_q;
    idx_d      = idx_q;

    if (cmd_i.act_en) begin
      case (act_kind)
        ACT_IDLE: begin
          if (cb == CH_ESC) begin
            mode_d     = MODE_ESC;
            cnt_d      = CNT_W'(1);
            last_esc_d = 1'b1;
          end else begin
            mode_d     = MODE_IDLE;
            cnt_d      = '0;
            last_esc_d = 1'b0;
          end
        end
        ACT_OPEN: begin
          mode_d     = MODE_SEQ;
          cnt_d      = CNT_W'(2);
          last_esc_d = 1'b0;
          tr_bold_d  = sty_bold_q;
          tr_fg_d    = sty_fg_q;
          tok_d      = '0;
          tok_inv_d  = 1'b0;
        end
        ACT_APPLY: begin
          mode_d     = MODE_IDLE;
          cnt_d      = '0;
          last_esc_d = 1'b0;
          sty_bold_d = ap_bold;
          sty_fg_d   = ap_fg;
          tr_bold_d  = ap_bold;
          tr_fg_d    = ap_fg;
          tok_d      = '0;
          tok_inv_d  = 1'b0;
          new_seg_d  = 1'b1;
        end
        ACT_STORE: begin
          cnt_d      = cnt_q + CNT_W'(1);
          last_esc_d = (cb == CH_ESC);
          if (cb >= CH_0 && cb <= CH_9) begin
            tok_d = tok_sat;
          end else if (cb == CH_SEMI) begin
            tr_bold_d = ap_bold;
            tr_fg_d   = ap_fg;
            tok_d     = '0;
            tok_inv_d = 1'b0;
          end else begin
            tok_inv_d = 1'b1;
          end
        end
        default: begin
          mode_d = mode_q;
        end
      endcase
    end

    if (cmd_i.emit && cmd_i.src != SRC_BARE) begin
      new_seg_d = 1'b0;
    end

    if (cmd_i.eol_clr) begin
      mode_d     = MODE_IDLE;
      cnt_d      = '0;
      last_esc_d = 1'b0;
      sty_bold_d = 1'b0;
      sty_fg_d   = '0;
      tr_bold_d  = 1'b0;
      tr_fg_d    = '0;
      tok_d      = '0;
      tok_inv_d  = 1'b0;
      new_seg_d  = 1'b1;
    end

    if (cmd_i.idx_clr) begin
      idx_d = '0;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_IDLE;
      cnt_q      <= '0;
      last_esc_q <= 1'b0;
      sty_bold_q <= 1'b0;
      sty_fg_q   <= '0;
      tr_bold_q  <= 1'b0;
      tr_fg_q    <= '0;
      tok_q      <= '0;
      tok_inv_q  <= 1'b0;
      new_seg_q  <= 1'b1;
      idx_q      <= '0;
    end else begin
      mode_q     <= mode_d;
      cnt_q      <= cnt_d;
      last_esc_q <= last_esc_d;
      sty_bold_q <= sty_bold_d;
      sty_fg_q   <= sty_fg_d;
      tr_bold_q  <= tr_bold_d;
      tr_fg_q    <= tr_fg_d;
      tok_q      <= tok_d;
      tok_inv_q  <= tok_inv_d;
      new_seg_q  <= new_seg_d;
      idx_q      <= idx_d;
    end
  end

  // Held bytes, captured input and result: no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.act_en) begin
      case (act_kind)
        ACT_IDLE: begin
          if (cb == CH_ESC) begin
            held_q[0] <= CH_ESC;
          end
        end
        ACT_OPEN: begin
          held_q[0] <= CH_ESC;
          held_q[1] <= CH_LBRK;
        end
        ACT_STORE: begin
          held_q[cnt_q[IDX_W-1:0]] <= cb;
        end
        default: begin
          held_q[0] <= held_q[0];
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      byte_q <= in_byte_i;
      eol_q  <= in_eol_i;
    end
    if (cmd_i.emit) begin
      case (cmd_i.src)
        SRC_HELD: begin
          res_q.char_out      <= held_q[idx_q];
          res_q.has_char      <= 1'b1;
          res_q.segment_start <= new_seg_q;
          res_q.overflow      <= cmd_i.ovf;
        end
        SRC_BYTE: begin
          res_q.char_out      <= cb;
          res_q.has_char      <= 1'b1;
          res_q.segment_start <= new_seg_q;
          res_q.overflow      <= 1'b0;
        end
        default: begin
          res_q.char_out      <= '0;
          res_q.has_char      <= 1'b0;
          res_q.segment_start <= 1'b0;
          res_q.overflow      <= 1'b0;
        end
      endcase
      res_q.bold      <= now_bold;
      res_q.fg_color  <= now_fg;
      res_q.line_done <= cmd_i.line_done;
      res_q.run_last  <= cmd_i.run_last;
    end
  end

  assign res_o = res_q;

  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_IDLE) |-> (cnt_q == '0))
    else $error("idle mode with held bytes");

  a_esc_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_ESC) |-> (cnt_q == CNT_W'(1) && last_esc_q))
    else $error("pending ESC not a single held ESC");

  a_seq_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_SEQ) |-> (cnt_q >= CNT_W'(2) && cnt_q <= DEPTH_C))
    else $error("held sequence count out of range");

endmodule

`default_nettype wire

[rtl/core/asgr_ctrl.sv]
// ----------------------------------------------------------------------------
// asgr_ctrl: sequencer of the SGR style parser
// Accepts bytes, steps buffer releases and owns the result valid flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module asgr_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  input  asgr_pkg::dp_status_t     status_i,
  output asgr_pkg::dp_cmd_t        cmd_o
);
  import asgr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,  // take a byte
    S_REP1 = 4'b0010,  // release held bytes before the action
    S_ACT  = 4'b0100,  // action on the captured byte
    S_REP2 = 4'b1000   // line end release of what is still held
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   can_load;

  assign can_load = !out_valid_q || out_ready_i;

  always_comb begin
    state_d          = state_q;
    in_ready_o       = 1'b0;
    cmd_o.latch      = 1'b0;
    cmd_o.use_in     = 1'b0;
    cmd_o.act_en     = 1'b0;
    cmd_o.idx_clr    = 1'b0;
    cmd_o.idx_inc    = 1'b0;
    cmd_o.emit       = 1'b0;
    cmd_o.src        = SRC_HELD;
    cmd_o.ovf        = 1'b0;
    cmd_o.line_done  = 1'b0;
    cmd_o.run_last   = 1'b0;
    cmd_o.eol_clr    = 1'b0;

    case (state_q)
      S_IDLE: begin
        in_ready_o   = can_load;
        cmd_o.use_in = 1'b1;
        if (in_valid_i && can_load) begin
          cmd_o.latch   = 1'b1;
          cmd_o.idx_clr = 1'b1;
          if (status_i.rep_zero) begin
            cmd_o.act_en    = 1'b1;
            cmd_o.emit      = status_i.emits_b || (status_i.eol && status_i.new_idle);
            cmd_o.src       = status_i.emits_b ? SRC_BYTE : SRC_BARE;
            cmd_o.line_done = status_i.eol;
            cmd_o.run_last  = 1'b1;
            if (status_i.eol && !status_i.new_idle) begin
              state_d = S_REP2;
            end else begin
              cmd_o.eol_clr = status_i.eol;
            end
          end else begin
            state_d = S_REP1;
          end
        end
      end
      S_REP1: begin
        if (can_load) begin
          cmd_o.emit     = 1'b1;
          cmd_o.src      = SRC_HELD;
          cmd_o.ovf      = status_i.rep_ovf;
          cmd_o.run_last = status_i.last_rep && !status_i.eol && !status_i.emits_b;
          cmd_o.idx_inc  = 1'b1;
          if (status_i.last_rep) begin
            state_d = S_ACT;
          end
        end
      end
      S_ACT: begin
        if (can_load) begin
          cmd_o.act_en    = 1'b1;
          cmd_o.emit      = status_i.emits_b;
          cmd_o.src       = SRC_BYTE;
          cmd_o.line_done = status_i.eol;
          cmd_o.run_last  = 1'b1;
          cmd_o.idx_clr   = 1'b1;
          if (status_i.eol && !status_i.new_idle) begin
            state_d = S_REP2;
          end else begin
            cmd_o.eol_clr = status_i.eol;
            state_d       = S_IDLE;
          end
        end
      end
      S_REP2: begin
        if (can_load) begin
          cmd_o.emit      = 1'b1;
          cmd_o.src       = SRC_HELD;
          cmd_o.line_done = status_i.last_held;
          cmd_o.run_last  = status_i.last_held;
          cmd_o.idx_inc   = 1'b1;
          if (status_i.last_held) begin
            cmd_o.eol_clr = 1'b1;
            state_d       = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = cmd_o.emit ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_emit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> (!out_valid_q || out_ready_i))
    else $error("result overwrites an untaken result");

  a_rep2_eol: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_REP2) |-> status_i.eol)
    else $error("line end release without line end");

  a_act_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ACT) |-> ($past(state_q) == S_REP1 || $past(state_q) == S_ACT))
    else $error("action state entered without a release");

endmodule

`default_nettype wire

[rtl/core/ansi_sgr_style_parser.sv]
// ----------------------------------------------------------------------------
// ansi_sgr_style_parser: streaming ANSI SGR escape parser
// Strips ESC '[' ... 'm' style sequences from a text line and tags each
// printable byte with bold, foreground color and segment marks.
// ----------------------------------------------------------------------------
//
//  channel | dir | transfer carries
//  --------+-----+------------------------------------------------------------
//  in_i    | in  | byte_in, end_of_line
//  out_o   | out | char_out, has_char, bold, fg_color, segment_start,
//          |     | overflow, line_done, run_last
//
// Steps: a plain byte, a held parameter byte, ESC, or a closing 'm' is
// handled as it is accepted. A byte that fails or overflows a held sequence
// is accepted, then the held bytes are released (S_REP1), then its own
// action runs (S_ACT); a line end with a sequence still open then releases
// each held byte (S_REP2). The release loop reads the held buffer one entry
// per cycle through the single result register while it can be loaded.
// Reset: asynchronous, active low; parse idle, default style, no clearing
// pass (buffer contents are only read after being written).
// Stalls: a result waits in the output register while the next byte is
// taken, as long as that register is free or being drained.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ansi_sgr_style_parser (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  asgr_in_if.sink      in_i,
  asgr_out_if.source   out_o
);
  import asgr_pkg::*;

  dp_cmd_t    cmd;     // controller -> datapath
  dp_status_t status;  // datapath -> controller
  res_t       res;

  // Sequencer: handshakes, release stepping, line end handling
  asgr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Parse state, held buffer, style registers, result register
  asgr_datapath u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_byte_i (in_i.byte_in),
    .in_eol_i  (in_i.end_of_line),
    .cmd_i     (cmd),
    .status_o  (status),
    .res_o     (res)
  );

  assign out_o.char_out      = res.char_out;
  assign out_o.has_char      = res.has_char;
  assign out_o.bold          = res.bold;
  assign out_o.fg_color      = res.fg_color;
  assign out_o.segment_start = res.segment_start;
  assign out_o.overflow      = res.overflow;
  assign out_o.line_done     = res.line_done;
  assign out_o.run_last      = res.run_last;

endmodule

`default_nettype wire

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: self-checking bench for ansi_sgr_style_parser
// Streams text lines with embedded SGR escapes into the byte channel. A
// behavioral scoreboard predicts the styled character stream, and every
// result transfer is checked field by field. Both channels stall at random,
// and the result side is held off once for a long stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import asgr_pkg::*;

  // Run shape
  localparam int unsigned BUF_DEPTH    = SEQ_BUFFER_DEPTH;
  localparam int unsigned RAND_ITEMS   = 405;   // on top of the directed lines
  localparam int unsigned TAIL_ITEMS   = 50;    // final stretch runs without gaps
  localparam int unsigned HOLD_AFTER   = 40;    // long sink hold-off starts here
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 2 * BUF_DEPTH + 8;
  localparam int unsigned MAX_REPORTS  = 10;

  // Byte codes
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_ESC     = 8'h1B;
  localparam logic [7:0] CH_LBRK    = 8'h5B;  // '['
  localparam logic [7:0] CH_SGR_END = 8'h6D;  // 'm'
  localparam logic [7:0] CH_SEP     = 8'h3B;  // ';'
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_Q       = 8'h51;
  localparam logic [7:0] CH_HIGH    = 8'hFF;
  localparam logic [7:0] FINAL_LO   = 8'h40;  // final-byte range of a CSI
  localparam logic [7:0] FINAL_HI   = 8'h7E;

  // SGR parameter codes
  localparam int unsigned SGR_RESET      = 0;
  localparam int unsigned SGR_BOLD       = 1;
  localparam int unsigned SGR_NORMAL     = 22;
  localparam int unsigned SGR_FG_LO      = 30;
  localparam int unsigned SGR_FG_HI      = 37;
  localparam int unsigned SGR_FG_DEFAULT = 39;
  localparam int unsigned SGR_BRIGHT_LO  = 90;
  localparam int unsigned SGR_BRIGHT_HI  = 97;
  localparam int unsigned PARAM_SAT      = 127;
  localparam int unsigned FG_BRIGHT_BASE = 9;   // fg index of code 90

  typedef enum logic [1:0] {
    SCAN_TEXT,  // plain text
    SCAN_ESC,   // ESC seen, waiting for '['
    SCAN_CSI    // inside ESC '[' ..., bytes held
  } scan_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       eol;
  } text_byte_t;

  logic clk_i;
  logic rst_ni;

  asgr_in_if  text_ch ();
  asgr_out_if style_ch ();

  ansi_sgr_style_parser DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (text_ch),
    .out_o  (style_ch)
  );

  // --------------------------------------------------------------------------
  // Scoreboard state: parser shadow, current and pending (trial) style
  // --------------------------------------------------------------------------
  scan_e       scan      = SCAN_TEXT;
  logic [7:0]  csi_buf [BUF_DEPTH];
  int unsigned csi_len   = 0;
  logic        sty_bold  = 1'b0;
  logic [4:0]  sty_fg    = '0;
  logic        pend_bold = 1'b0;
  logic [4:0]  pend_fg   = '0;
  logic [6:0]  param_val = '0;
  logic        param_bad = 1'b0;
  logic        seg_next  = 1'b1;   // next printed char opens a segment

  res_t       byte_results[$];     // results caused by the byte being predicted
  res_t       exp_styled[$];       // styled results still to come from the DUT
  text_byte_t text_q[$];           // text bytes not yet offered

  int unsigned bytes_total   = 0;
  int unsigned bytes_taken   = 0;
  int unsigned mismatches    = 0;
  logic        byte_accepted = 1'b0;
  logic        tail_phase    = 1'b0;
  logic        busy_phase    = 1'b0;
  int unsigned send_gap      = 0;
  int unsigned recv_gap      = 0;
  int unsigned hold_left     = 0;
  logic        hold_done     = 1'b0;

  // --------------------------------------------------------------------------
  // Style prediction
  // --------------------------------------------------------------------------

  // One result with the style in force. A real char consumes the segment mark.
  function automatic void emit_result(logic [7:0] ch, logic has, logic ovf);
    res_t r;
    r               = '0;
    r.char_out      = has ? ch : CH_NUL;
    r.has_char      = has;
    r.bold          = sty_bold;
    r.fg_color      = sty_fg;
    r.segment_start = has & seg_next;
    r.overflow      = ovf;
    if (has) seg_next = 1'b0;
    byte_results = {byte_results, r};
  endfunction

  // Held bytes go out as plain text
  function automatic void flush_held(int unsigned upto, logic ovf);
    for (int unsigned k = 0; k < upto && k < BUF_DEPTH; k++)
      emit_result(csi_buf[k], 1'b1, ovf);
  endfunction

  function automatic void open_csi();
    csi_buf[0] = CH_ESC;
    csi_buf[1] = CH_LBRK;
    csi_len    = 2;
    scan       = SCAN_CSI;
    pend_bold  = sty_bold;
    pend_fg    = sty_fg;
    param_val  = '0;
    param_bad  = 1'b0;
  endfunction

  // Apply the finished parameter to the trial style; junk tokens do nothing
  function automatic void apply_param();
    if (!param_bad) begin
      if (param_val == SGR_RESET) begin
        pend_bold = 1'b0;
        pend_fg   = '0;
      end else if (param_val == SGR_BOLD) begin
        pend_bold = 1'b1;
      end else if (param_val == SGR_NORMAL) begin
        pend_bold = 1'b0;
      end else if (param_val >= SGR_FG_LO && param_val <= SGR_FG_HI) begin
        pend_fg = 5'(param_val - SGR_FG_LO + 1);
      end else if (param_val == SGR_FG_DEFAULT) begin
        pend_fg = '0;
      end else if (param_val >= SGR_BRIGHT_LO && param_val <= SGR_BRIGHT_HI) begin
        pend_fg = 5'(param_val - SGR_BRIGHT_LO + FG_BRIGHT_BASE);
      end
    end
    param_val = '0;
    param_bad = 1'b0;
  endfunction

  // Byte handling. A lone ESC or an overflow drops back to text mode and the
  // same byte is looked at again from there.
  function automatic void take_byte(logic [7:0] b);
    logic        again;
    int unsigned acc;
    again = 1'b1;
    while (again) begin
      again = 1'b0;
      case (scan)
        SCAN_ESC: begin
          if (b == CH_LBRK) begin
            open_csi();
          end else begin
            flush_held(csi_len, 1'b0);
            csi_len = 0;
            scan    = SCAN_TEXT;
            again   = 1'b1;
          end
        end
        SCAN_CSI: begin
          if (b == CH_SGR_END) begin
            apply_param();
            sty_bold = pend_bold;
            sty_fg   = pend_fg;
            seg_next = 1'b1;
            csi_len  = 0;
            scan     = SCAN_TEXT;
          end else if (b >= FINAL_LO && b <= FINAL_HI) begin
            // trailing ESC '[' restarts the sequence instead of failing it
            if (b == CH_LBRK && csi_len > 2 && csi_len <= BUF_DEPTH &&
                csi_buf[csi_len - 1] == CH_ESC) begin
              flush_held(csi_len - 1, 1'b0);
              open_csi();
            end else begin
              flush_held(csi_len, 1'b0);
              emit_result(b, 1'b1, 1'b0);
              csi_len = 0;
              scan    = SCAN_TEXT;
            end
          end else if (csi_len >= BUF_DEPTH) begin
            flush_held(csi_len, 1'b1);
            csi_len = 0;
            scan    = SCAN_TEXT;
            again   = 1'b1;
          end else begin
            csi_buf[csi_len] = b;
            csi_len++;
            if (b >= CH_ZERO && b <= CH_NINE) begin
              acc       = param_val * 10 + (b - CH_ZERO);
              param_val = (acc > PARAM_SAT) ? 7'(PARAM_SAT) : 7'(acc);
            end else if (b == CH_SEP) begin
              apply_param();
            end else begin
              param_bad = 1'b1;
            end
          end
        end
        default: begin
          if (b == CH_ESC) begin
            csi_buf[0] = CH_ESC;
            csi_len    = 1;
            scan       = SCAN_ESC;
          end else begin
            emit_result(b, 1'b1, 1'b0);
          end
        end
      endcase
    end
  endfunction

  // Expected results of one accepted text byte, appended to exp_styled
  function automatic void predict_styled(logic [7:0] b, logic eol);
    res_t r;
    byte_results.delete();
    take_byte(b);
    if (eol) begin
      // an open sequence or pending ESC is cut off and printed
      if (scan != SCAN_TEXT) flush_held(csi_len, 1'b0);
      csi_len = 0;
      scan    = SCAN_TEXT;
      if (byte_results.size() == 0) emit_result(CH_NUL, 1'b0, 1'b0);
      r = byte_results.pop_back();
      r.line_done = 1'b1;
      byte_results = {byte_results, r};
      sty_bold  = 1'b0;
      sty_fg    = '0;
      pend_bold = 1'b0;
      pend_fg   = '0;
      param_val = '0;
      param_bad = 1'b0;
      seg_next  = 1'b1;
    end
    if (byte_results.size() != 0) begin
      r = byte_results.pop_back();
      r.run_last = 1'b1;
      byte_results = {byte_results, r};
    end
    exp_styled = {exp_styled, byte_results};
  endfunction

  function automatic string show(res_t r);
    return $sformatf("ch=%02h has=%b bold=%b fg=%0d seg=%b ovf=%b done=%b last=%b",
                     r.char_out, r.has_char, r.bold, r.fg_color, r.segment_start,
                     r.overflow, r.line_done, r.run_last);
  endfunction

  // --------------------------------------------------------------------------
  // Text builders
  // --------------------------------------------------------------------------
  function automatic void put_byte(logic [7:0] b);
    text_byte_t t;
    t.ch  = b;
    t.eol = 1'b0;
    text_q = {text_q, t};
  endfunction

  function automatic void close_line();
    text_byte_t t;
    t = text_q.pop_back();
    t.eol = 1'b1;
    text_q = {text_q, t};
  endfunction

  // Decimal digits, no leading zeros, up to three digits
  function automatic void put_number(int unsigned v);
    if (v >= 100) put_byte(8'(CH_ZERO + v / 100));
    if (v >= 10) put_byte(8'(CH_ZERO + (v / 10) % 10));
    put_byte(8'(CH_ZERO + v % 10));
  endfunction

  // Parameter byte that is neither a digit nor a separator (poisons a token)
  function automatic logic [7:0] odd_param_byte();
    case ($urandom_range(0, 3))
      0:       return 8'($urandom_range(8'h20, 8'h2F));
      1:       return 8'($urandom_range(8'h3C, 8'h3F));
      2:       return 8'($urandom_range(8'h00, 8'h1F));
      default: return 8'($urandom_range(8'h80, 8'hFF));
    endcase
  endfunction

  // One SGR token: listed codes, empty, unlisted/huge, leading zero, junk
  function automatic void put_param();
    case ($urandom_range(0, 9))
      0: ;  // empty token acts as a reset
      1: put_number(SGR_RESET);
      2: put_number(SGR_BOLD);
      3: put_number(SGR_NORMAL);
      4: put_number($urandom_range(SGR_FG_LO, SGR_FG_HI));
      5: put_number($urandom_range(SGR_BRIGHT_LO, SGR_BRIGHT_HI));
      6: put_number(SGR_FG_DEFAULT);
      7: put_number($urandom_range(0, 999));
      8: begin
        put_byte(CH_ZERO);
        put_number($urandom_range(0, SGR_BRIGHT_HI));
      end
      default: begin
        put_number($urandom_range(0, 99));
        put_byte(odd_param_byte());
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Clock, watchdog
  // --------------------------------------------------------------------------
  initial begin : clock_gen
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Generous bound: far above a worst-case run
  initial begin : watchdog
    #1000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of test
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned kind;
    int unsigned n_params;
    rst_ni               = 1'b0;
    text_ch.valid        = 1'b0;
    text_ch.byte_in      = CH_NUL;
    text_ch.end_of_line  = 1'b0;
    style_ch.ready       = 1'b0;

    // Directed line 1: the buffer fills with a saturating number, a NUL and
    // 0xFF poisoning it, then one more parameter byte spills it as overflow.
    // The spilling ';' then prints from text mode and ends the line.
    put_byte(CH_ESC);
    put_byte(CH_LBRK);
    put_number(123);
    put_number(4);
    put_byte(CH_NUL);
    put_byte(CH_HIGH);
    put_byte(CH_SEP);
    repeat (BUF_DEPTH - 9) put_byte(CH_NINE);
    put_byte(CH_SEP);
    close_line();

    // Directed line 2: lone ESC, then ESC '[' ESC '[' restarts the sequence,
    // bold applies and the line ends on 'm' with nothing printed (bare end).
    put_byte(CH_ESC);
    put_byte(CH_Q);
    put_byte(CH_ESC);
    put_byte(CH_LBRK);
    put_byte(CH_ESC);
    put_byte(CH_LBRK);
    put_number(SGR_BOLD);
    put_byte(CH_SGR_END);
    close_line();

    // Random lines, mostly well formed SGR and text, the rest broken
    while (text_q.size() < 25 + RAND_ITEMS) begin
      repeat ($urandom_range(1, 6)) begin
        kind = $urandom_range(0, 99);
        if (kind < 30) begin
          // raw bytes, any value
          repeat ($urandom_range(1, 5)) put_byte(8'($urandom_range(0, 255)));
        end else if (kind < 70) begin
          // well formed SGR, zero to three tokens
          put_byte(CH_ESC);
          put_byte(CH_LBRK);
          n_params = $urandom_range(0, 3);
          for (int t = 0; t < n_params; t++) begin
            if (t != 0) put_byte(CH_SEP);
            put_param();
          end
          put_byte(CH_SGR_END);
        end else if (kind < 78) begin
          // sequence closed by a random final byte, usually not 'm'
          put_byte(CH_ESC);
          put_byte(CH_LBRK);
          put_param();
          put_byte(8'($urandom_range(FINAL_LO, FINAL_HI)));
        end else if (kind < 84) begin
          // ESC followed by anything
          put_byte(CH_ESC);
          put_byte(8'($urandom_range(0, 255)));
        end else if (kind < 90) begin
          // sequence interrupted by a fresh ESC '['
          put_byte(CH_ESC);
          put_byte(CH_LBRK);
          put_param();
          put_byte(CH_ESC);
          put_byte(CH_LBRK);
          put_param();
          put_byte(CH_SGR_END);
        end else if (kind < 95) begin
          // long parameter run around the buffer size
          put_byte(CH_ESC);
          put_byte(CH_LBRK);
          repeat ($urandom_range(BUF_DEPTH - 4, BUF_DEPTH + 2))
            put_byte(($urandom_range(0, 4) == 0) ? odd_param_byte() :
                     ($urandom_range(0, 3) == 0) ? CH_SEP :
                     8'(CH_ZERO + $urandom_range(0, 9)));
        end else begin
          // left open: the next chunk or the line end cuts it off
          put_byte(CH_ESC);
          put_byte(CH_LBRK);
          put_param();
        end
      end
      close_line();
    end
    bytes_total = text_q.size();

    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    while (bytes_taken < bytes_total || exp_styled.size() != 0) @(posedge clk_i);
    // catch any stray result after the last expected one
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Input side: transfers are seen at the rising edge, new bytes are offered
  // at the falling edge.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    byte_accepted = (rst_ni && text_ch.valid && text_ch.ready) === 1'b1;
    if (byte_accepted) begin
      predict_styled(text_ch.byte_in, text_ch.end_of_line);
      bytes_taken++;
    end
    // gaps only outside the tail, and only in the first 48 of every 64 bytes
    tail_phase = bytes_taken + TAIL_ITEMS >= bytes_total;
    busy_phase = !tail_phase && (bytes_taken % 64) < 48;
  end

  always @(negedge clk_i) begin : text_driver
    text_byte_t nxt;
    // a byte on offer stays put until it is taken
    if (rst_ni && !(text_ch.valid && !byte_accepted)) begin
      if (send_gap == 0 && busy_phase && $urandom_range(0, 5) == 0)
        send_gap = $urandom_range(1, 10);
      if (send_gap != 0) begin
        send_gap--;
        text_ch.valid <= 1'b0;
      end else if (text_q.size() != 0) begin
        nxt = text_q.pop_front();
        text_ch.valid       <= 1'b1;
        text_ch.byte_in     <= nxt.ch;
        text_ch.end_of_line <= nxt.eol;
      end else begin
        text_ch.valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output side: random short stalls, plus one long hold-off early in the
  // random part while the sender keeps offering bytes, so the block backs up
  // and has to drop its input ready.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!hold_done && bytes_taken >= HOLD_AFTER) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(negedge clk_i) begin : result_sink
    logic stall;
    if (rst_ni) begin
      if (recv_gap == 0 && busy_phase && $urandom_range(0, 4) == 0)
        recv_gap = $urandom_range(1, 10);
      stall = (recv_gap != 0);
      if (stall) recv_gap--;
      style_ch.ready <= !stall && hold_left == 0;
    end
  end

  // Every result transfer is matched against the oldest expectation
  always @(posedge clk_i) begin : style_monitor
    res_t got;
    res_t want;
    if ((rst_ni && style_ch.valid && style_ch.ready) === 1'b1) begin
      got.char_out      = style_ch.char_out;
      got.has_char      = style_ch.has_char;
      got.bold          = style_ch.bold;
      got.fg_color      = style_ch.fg_color;
      got.segment_start = style_ch.segment_start;
      got.overflow      = style_ch.overflow;
      got.line_done     = style_ch.line_done;
      got.run_last      = style_ch.run_last;
      if (exp_styled.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result with none expected: %s", $realtime, show(got));
      end else begin
        want = exp_styled.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("%0t: result mismatch", $realtime);
            $display("  expected %s", show(want));
            $display("  actual   %s", show(got));
          end
        end
      end
    end
  end

endmodule

[filelist.f]
rtl/core/asgr_pkg.sv
rtl/core/asgr_if.sv
rtl/core/asgr_datapath.sv
rtl/core/asgr_ctrl.sv
rtl/core/ansi_sgr_style_parser.sv
dv/testbench.sv
